// ===== hw/rtl/tpa_pkg.sv =====
// tpa_pkg: shared types and codes of the two-pool id allocator
// used by tpa_scan, tpa_bitmap and two_pool_id_allocator; no dependencies
package tpa_pkg;

  localparam int ID_W     = 6;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;
  localparam int CMP_W    = ID_W + 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NONE      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_TAKEN = 2'd3
  } status_t;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_COMMON  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SPECIAL = 2'd1;

  // sequencer commands to the offset walker
  typedef struct packed {
    logic load;
    logic step;
  } scan_ctl_t;

  // bitmap write strobe and the bit written (1 free, 0 taken)
  typedef struct packed {
    logic we;
    logic val;
  } map_wr_t;

endpackage

// ===== hw/rtl/tpa_scan.sv =====
// tpa_scan: circular offset walker shared by both pools
// depends on tpa_pkg for scan_ctl_t
module tpa_scan #(
  parameter int OFF_W = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tpa_pkg::scan_ctl_t ctl,
  input  logic [OFF_W-1:0]   start_off,
  input  logic [OFF_W-1:0]   count_m1,
  output logic [OFF_W-1:0]   off,
  output logic               last
);

  logic [OFF_W-1:0] off_r, off_nxt;
  logic [OFF_W-1:0] k_r, k_nxt;

  always_comb begin
    off_nxt = off_r;
    k_nxt   = k_r;
    if (ctl.load) begin
      off_nxt = start_off;
      k_nxt   = '0;
    end else if (ctl.step) begin
      // wrap inside the pool
      off_nxt = (off_r == count_m1) ? '0 : off_r + OFF_W'(1);
      k_nxt   = k_r + OFF_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
      k_r   <= '0;
    end else begin
      off_r <= off_nxt;
      k_r   <= k_nxt;
    end
  end

  assign off  = off_r;
  assign last = (k_r == count_m1);

endmodule

// ===== hw/rtl/tpa_bitmap.sv =====
// tpa_bitmap: free bitmap in flip-flops, one address shared by read and write
// depends on tpa_pkg for map_wr_t
module tpa_bitmap #(
  parameter int TOTAL  = 32,
  parameter int SLOT_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [SLOT_W-1:0] addr,
  input  tpa_pkg::map_wr_t  wr,
  output logic              rd_free
);

  logic [TOTAL-1:0] map_r, map_nxt;

  always_comb begin
    map_nxt = map_r;
    if (wr.we) begin
      map_nxt[addr] = wr.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '1;
    end else begin
      map_r <= map_nxt;
    end
  end

  assign rd_free = map_r[addr];

endmodule

// ===== hw/rtl/two_pool_id_allocator.sv =====
// two_pool_id_allocator: top level with request sequencer and result register
// depends on tpa_pkg, tpa_scan and tpa_bitmap
//
// Usage: one request channel (in_valid/in_ready) carries opcode, pool_kind
// and release_id; one result channel (out_valid/out_ready) returns status
// and granted_id, exactly one result per request, in request order.
// An allocate walks the named pool one slot per cycle from the pool's
// start pointer, through the shared offset walker and the single bitmap
// read port; it passes through an accept step, the scan and a load of the
// result register, in that order. A release has an accept step, one
// execute step and the load; an allocate to an invalid pool skips the scan.
// The block handles one request at a time; in_ready is high only while
// it waits for a new request. A result left untaken in the output register
// does not block the next request, which is accepted and processed; only
// its own result then waits until out_ready frees the register.
// Reset (rst_n low, synchronous) marks every id free, sets both start
// pointers to zero and drops out_valid.
module two_pool_id_allocator #(
  parameter int COMMON_COUNT  = 16,
  parameter int SPECIAL_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [tpa_pkg::KIND_W-1:0]    in_pool_kind,
  input  logic [tpa_pkg::ID_W-1:0]      in_release_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tpa_pkg::STATUS_W-1:0]  out_status,
  output logic [tpa_pkg::ID_W-1:0]      out_granted_id
);

  localparam int TOTAL  = COMMON_COUNT + SPECIAL_COUNT;
  localparam int SLOT_W = $clog2(TOTAL);
  localparam int MAXC   = (COMMON_COUNT > SPECIAL_COUNT) ? COMMON_COUNT : SPECIAL_COUNT;
  localparam int OFF_W  = (MAXC > 1) ? $clog2(MAXC) : 1;

  localparam logic [OFF_W-1:0]  COMMON_M1  = OFF_W'(COMMON_COUNT - 1);
  localparam logic [OFF_W-1:0]  SPECIAL_M1 = OFF_W'(SPECIAL_COUNT - 1);
  localparam logic [SLOT_W-1:0] SPECIAL_BASE = SLOT_W'(COMMON_COUNT);
  localparam logic [tpa_pkg::CMP_W-1:0] TOTAL_CMP = tpa_pkg::CMP_W'(TOTAL);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic                          op_r, op_nxt;
  logic                          special_r, special_nxt;
  logic [tpa_pkg::ID_W-1:0]      rid_r, rid_nxt;
  tpa_pkg::status_t              res_status_r, res_status_nxt;
  logic [tpa_pkg::ID_W-1:0]      res_id_r, res_id_nxt;
  logic                          out_valid_r, out_valid_nxt;
  tpa_pkg::status_t              out_status_r, out_status_nxt;
  logic [tpa_pkg::ID_W-1:0]      out_id_r, out_id_nxt;
  logic [OFF_W-1:0]              common_start_r, common_start_nxt;
  logic [OFF_W-1:0]              special_start_r, special_start_nxt;

  tpa_pkg::scan_ctl_t            scan_ctl;
  tpa_pkg::map_wr_t              map_wr;
  logic [OFF_W-1:0]              scan_start;
  logic [OFF_W-1:0]              scan_count_m1;
  logic [OFF_W-1:0]              scan_off;
  logic                          scan_last;
  logic [SLOT_W-1:0]             scan_slot;
  logic [SLOT_W-1:0]             map_addr;
  logic                          map_free;
  logic [tpa_pkg::CMP_W-1:0]     rid_ext;
  logic [tpa_pkg::CMP_W-1:0]     rid_m1;
  logic [tpa_pkg::CMP_W-1:0]     grant_sum;
  logic                          rid_bad;
  logic                          in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign scan_start    = (in_pool_kind == tpa_pkg::KIND_SPECIAL) ? special_start_r
                                                                 : common_start_r;
  assign scan_count_m1 = special_r ? SPECIAL_M1 : COMMON_M1;
  assign scan_slot     = special_r ? SPECIAL_BASE + SLOT_W'(scan_off) : SLOT_W'(scan_off);

  assign rid_ext   = tpa_pkg::CMP_W'(rid_r);
  assign rid_m1    = rid_ext - tpa_pkg::CMP_W'(1);
  assign rid_bad   = (rid_r == '0) || (rid_ext > TOTAL_CMP);
  assign map_addr  = (op_r == tpa_pkg::OP_RELEASE) ? rid_m1[SLOT_W-1:0] : scan_slot;
  assign grant_sum = tpa_pkg::CMP_W'(map_addr) + tpa_pkg::CMP_W'(1);

  tpa_scan #(
    .OFF_W (OFF_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .start_off (scan_start),
    .count_m1  (scan_count_m1),
    .off       (scan_off),
    .last      (scan_last)
  );

  tpa_bitmap #(
    .TOTAL  (TOTAL),
    .SLOT_W (SLOT_W)
  ) u_bitmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .addr    (map_addr),
    .wr      (map_wr),
    .rd_free (map_free)
  );

  always_comb begin
    state_nxt         = state_r;
    op_nxt            = op_r;
    special_nxt       = special_r;
    rid_nxt           = rid_r;
    res_status_nxt    = res_status_r;
    res_id_nxt        = res_id_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_status_nxt    = out_status_r;
    out_id_nxt        = out_id_r;
    common_start_nxt  = common_start_r;
    special_start_nxt = special_start_r;
    scan_ctl          = '0;
    map_wr            = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_opcode;
          special_nxt = (in_pool_kind == tpa_pkg::KIND_SPECIAL);
          rid_nxt     = in_release_id;
          res_id_nxt  = '0;
          if (in_opcode == tpa_pkg::OP_RELEASE) begin
            state_nxt = S_EXEC;
          end else if (in_pool_kind == tpa_pkg::KIND_COMMON) begin
            scan_ctl.load    = 1'b1;
            common_start_nxt = (common_start_r == COMMON_M1) ? '0
                                                             : common_start_r + OFF_W'(1);
            state_nxt        = S_EXEC;
          end else if (in_pool_kind == tpa_pkg::KIND_SPECIAL) begin
            scan_ctl.load     = 1'b1;
            special_start_nxt = (special_start_r == SPECIAL_M1) ? '0
                                                                : special_start_r + OFF_W'(1);
            state_nxt         = S_EXEC;
          end else begin
            // invalid pool: nothing moves
            res_status_nxt = tpa_pkg::ST_NONE;
            state_nxt      = S_DONE;
          end
        end
      end
      S_EXEC: begin
        if (op_r == tpa_pkg::OP_RELEASE) begin
          state_nxt = S_DONE;
          if (rid_bad) begin
            res_status_nxt = tpa_pkg::ST_RANGE;
          end else if (map_free) begin
            res_status_nxt = tpa_pkg::ST_NOT_TAKEN;
          end else begin
            map_wr.we      = 1'b1;
            map_wr.val     = 1'b1;
            res_status_nxt = tpa_pkg::ST_OK;
          end
        end else if (map_free) begin
          map_wr.we      = 1'b1;
          map_wr.val     = 1'b0;
          res_status_nxt = tpa_pkg::ST_OK;
          res_id_nxt     = grant_sum[tpa_pkg::ID_W-1:0];
          state_nxt      = S_DONE;
        end else if (scan_last) begin
          res_status_nxt = tpa_pkg::ST_NONE;
          state_nxt      = S_DONE;
        end else begin
          scan_ctl.step = 1'b1;
        end
      end
      S_DONE: begin
        // wait for the output register to drain
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      common_start_r  <= '0;
      special_start_r <= '0;
    end else begin
      state_r         <= state_nxt;
      out_valid_r     <= out_valid_nxt;
      common_start_r  <= common_start_nxt;
      special_start_r <= special_start_nxt;
    end
    op_r         <= op_nxt;
    special_r    <= special_nxt;
    rid_r        <= rid_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_granted_id = out_id_r;

  // only a successful allocate carries an id
  a_id_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != tpa_pkg::ST_OK) |-> (out_granted_id == '0))
    else $error("granted id set on a failed transaction");

  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    map_wr.we |-> (state_r == S_EXEC))
    else $error("bitmap written outside execution");

  a_common_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_opcode == tpa_pkg::OP_ALLOC) && (in_pool_kind == tpa_pkg::KIND_COMMON)
    && (COMMON_COUNT > 1) |=> (common_start_r != $past(common_start_r)))
    else $error("common start pointer did not advance");

  a_off_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && (op_r == tpa_pkg::OP_ALLOC) |-> (scan_off <= scan_count_m1))
    else $error("scan offset left its pool");

  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_valid_r && !out_ready |=> (state_r == S_DONE))
    else $error("result dropped while output stalled");

endmodule

// ===== verif/tpa_grant_checker.sv =====
// tpa_grant_checker: watches both channels of the two-pool id allocator,
// predicts each result from the request stream and compares in order
// depends on tpa_pkg
module tpa_grant_checker #(
  parameter int COMMON_COUNT  = 16,
  parameter int SPECIAL_COUNT = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_opcode,
  input  logic [tpa_pkg::KIND_W-1:0]   in_pool_kind,
  input  logic [tpa_pkg::ID_W-1:0]     in_release_id,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [tpa_pkg::STATUS_W-1:0] out_status,
  input  logic [tpa_pkg::ID_W-1:0]     out_granted_id,
  output int                           mismatch_count,
  output int                           grants_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_IDS = COMMON_COUNT + SPECIAL_COUNT;

  typedef struct packed {
    tpa_pkg::status_t            status;
    logic [tpa_pkg::ID_W-1:0]    granted_id;
  } answer_t;

  logic [TOTAL_IDS-1:0] id_free;
  int                   common_ptr;
  int                   special_ptr;
  answer_t              answers[$];
  int                   errors = 0;

  // circular first-free search in one pool from its pointer; valid-pool allocates move it on by one
  function automatic answer_t serve_request(input logic op,
                                            input logic [tpa_pkg::KIND_W-1:0] kind,
                                            input logic [tpa_pkg::ID_W-1:0] rid);
    answer_t ans;
    int      slot;
    int      base;
    int      count;
    int      off;
    ans.status     = tpa_pkg::ST_OK;
    ans.granted_id = '0;
    slot  = -1;
    base  = 0;
    count = 0;
    off   = 0;
    if (op == tpa_pkg::OP_ALLOC) begin
      if (kind == tpa_pkg::KIND_COMMON) begin
        count      = COMMON_COUNT;
        off        = common_ptr;
        common_ptr = (common_ptr + 1) % COMMON_COUNT;
      end else if (kind == tpa_pkg::KIND_SPECIAL) begin
        base        = COMMON_COUNT;
        count       = SPECIAL_COUNT;
        off         = special_ptr;
        special_ptr = (special_ptr + 1) % SPECIAL_COUNT;
      end
      for (int k = 0; k < count; k++) begin
        if (slot < 0 && id_free[base + off]) slot = base + off;
        off = (off + 1) % count;
      end
      if (slot >= 0) begin
        id_free[slot]  = 1'b0;
        ans.granted_id = tpa_pkg::ID_W'(slot + 1);
      end else begin
        ans.status = tpa_pkg::ST_NONE;
      end
    end else begin
      if (rid == '0 || int'(rid) > TOTAL_IDS) begin
        ans.status = tpa_pkg::ST_RANGE;
      end else if (id_free[int'(rid) - 1]) begin
        ans.status = tpa_pkg::ST_NOT_TAKEN;
      end else begin
        id_free[int'(rid) - 1] = 1'b1;
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      id_free     = '1;
      common_ptr  = 0;
      special_ptr = 0;
      answers.delete();
    end else begin
      // the result leaving now belongs to an older transaction than the one entering
      if (out_valid && out_ready) begin
        if (answers.size() == 0) begin
          $error("unexpected result: status %0d granted_id %0d", out_status, out_granted_id);
          errors++;
        end else begin
          want = answers.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_granted_id !== want.granted_id) begin
            $error("granted_id: expected %0d, got %0d", want.granted_id, out_granted_id);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        answers.push_back(serve_request(in_opcode, in_pool_kind, in_release_id));
    end
    mismatch_count <= errors;
    grants_owed    <= answers.size();
  end

endmodule

// ===== verif/two_pool_id_allocator_tb.sv =====
// two_pool_id_allocator_tb: drives allocate and release requests into the
// allocator under varying idle and stall patterns and gives the verdict
// depends on tpa_pkg, tpa_grant_checker and the allocator rtl
module two_pool_id_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SEG_ITEMS     = 235;
  localparam int SETTLE_CYCLES = 20;

  localparam logic [tpa_pkg::KIND_W-1:0] KIND_BAD_LO = 2'd2;
  localparam logic [tpa_pkg::KIND_W-1:0] KIND_BAD_HI = 2'd3;
  localparam logic [tpa_pkg::ID_W-1:0]   ID_NONE     = 6'd0;
  localparam logic [tpa_pkg::ID_W-1:0]   ID_LAST     = 6'd32;
  localparam logic [tpa_pkg::ID_W-1:0]   ID_OVER     = 6'd33;
  localparam logic [tpa_pkg::ID_W-1:0]   ID_MAX      = 6'd63;

  logic                         clk           = 1'b0;
  logic                         rst_n         = 1'b0;
  logic                         in_valid      = 1'b0;
  logic                         in_opcode     = tpa_pkg::OP_ALLOC;
  logic [tpa_pkg::KIND_W-1:0]   in_pool_kind  = '0;
  logic [tpa_pkg::ID_W-1:0]     in_release_id = '0;
  logic                         out_ready     = 1'b0;
  logic                         in_ready;
  logic                         out_valid;
  logic [tpa_pkg::STATUS_W-1:0] out_status;
  logic [tpa_pkg::ID_W-1:0]     out_granted_id;

  int mismatch_count;
  int grants_owed;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int alloc_pct    = 50;
  int hold_asked   = 0;
  int hold_served  = 0;
  int quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  two_pool_id_allocator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_pool_kind   (in_pool_kind),
    .in_release_id  (in_release_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_granted_id (out_granted_id)
  );

  tpa_grant_checker grant_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_pool_kind   (in_pool_kind),
    .in_release_id  (in_release_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_granted_id (out_granted_id),
    .mismatch_count (mismatch_count),
    .grants_owed    (grants_owed)
  );

  // result side: random stalls, plus a long hold-off whenever one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        hold_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic put_request(input logic op, input logic [tpa_pkg::KIND_W-1:0] kind,
                             input logic [tpa_pkg::ID_W-1:0] rid);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_pool_kind  <= kind;
    in_release_id <= rid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (grants_owed != 0) @(posedge clk);
  endtask

  // mostly valid pools and in-range ids; the unused field is always noise
  task automatic random_request();
    logic                       op;
    logic [tpa_pkg::KIND_W-1:0] kind;
    logic [tpa_pkg::ID_W-1:0]   rid;
    op   = ($urandom_range(99) < alloc_pct) ? tpa_pkg::OP_ALLOC : tpa_pkg::OP_RELEASE;
    kind = tpa_pkg::KIND_W'($urandom_range(3));
    rid  = tpa_pkg::ID_W'($urandom_range(63));
    if (op == tpa_pkg::OP_ALLOC && $urandom_range(9) != 0)
      kind = $urandom_range(1) ? tpa_pkg::KIND_SPECIAL : tpa_pkg::KIND_COMMON;
    if (op == tpa_pkg::OP_RELEASE && $urandom_range(9) != 0)
      rid = tpa_pkg::ID_W'($urandom_range(ID_LAST, 1));
    put_request(op, kind, rid);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the common pool; the last one finds it full
    repeat (17) put_request(tpa_pkg::OP_ALLOC, tpa_pkg::KIND_COMMON,
                            tpa_pkg::ID_W'($urandom_range(63)));
    put_request(tpa_pkg::OP_ALLOC, KIND_BAD_LO, ID_MAX);
    put_request(tpa_pkg::OP_ALLOC, KIND_BAD_HI, ID_NONE);
    put_request(tpa_pkg::OP_RELEASE, KIND_BAD_HI, ID_NONE);
    put_request(tpa_pkg::OP_RELEASE, tpa_pkg::KIND_COMMON, ID_OVER);
    put_request(tpa_pkg::OP_RELEASE, tpa_pkg::KIND_SPECIAL, ID_MAX);
    put_request(tpa_pkg::OP_RELEASE, KIND_BAD_LO, ID_LAST);
    put_request(tpa_pkg::OP_RELEASE, tpa_pkg::KIND_COMMON, tpa_pkg::ID_W'(5));
    put_request(tpa_pkg::OP_RELEASE, tpa_pkg::KIND_COMMON, tpa_pkg::ID_W'(5));
    put_request(tpa_pkg::OP_ALLOC, tpa_pkg::KIND_SPECIAL, ID_MAX);
    drain_results();

    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_asked++;
        end
        1: begin
          idle_pct  = 80;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 80;
        end
        default: begin
          idle_pct  = 30;
          stall_pct = 30;
        end
      endcase
      // first half drives pools to full, second half drains them
      alloc_pct = (seg < 4) ? 70 : 35;
      repeat (SEG_ITEMS) random_request();
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && grants_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
